@@ hw/rtl/jmris_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jmris_pkg;

    // Control modes carried by each item.
    localparam logic [2:0] MODE_POSITION  = 3'd0;
    localparam logic [2:0] MODE_DIRECT    = 3'd1;
    localparam logic [2:0] MODE_VELOCITY  = 3'd2;
    localparam logic [2:0] MODE_TORQUE    = 3'd3;
    localparam logic [2:0] MODE_OPEN_LOOP = 3'd4;

    // Command kinds of a result item.
    localparam logic [1:0] KIND_POSITION = 2'd0;
    localparam logic [1:0] KIND_VELOCITY = 2'd1;
    localparam logic [1:0] KIND_TORQUE   = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_STEP_PERIOD = 1'b0;
    localparam logic CFG_DONE_TOL    = 1'b1;

    localparam logic [9:0]  STEP_PERIOD_RESET = 10'd1;
    localparam logic [30:0] DONE_TOL_RESET    = 31'd58982;

    // Long division by 1000, eight quotient bits per cycle over a 48-bit dividend.
    localparam int          DIV_BITS   = 8;
    localparam int          DIV_WIDTH  = 48;
    localparam int          DIV_CYCLES = DIV_WIDTH / DIV_BITS;
    localparam int          DIV_CNT_W  = 3;
    localparam logic [10:0] DIVISOR    = 11'd1000;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if ((&v[33:31]) || !(|v[33:31])) begin
            r = v[31:0];
        end else begin
            r = v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat46(input logic signed [45:0] v);
        logic signed [31:0] r;
        if ((&v[45:31]) || !(|v[45:31])) begin
            r = v[31:0];
        end else begin
            r = v[45] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/joint_mode_ramp_impedance_step.sv @@
// Per-joint position ramp with impedance control, one control tick per item.
//
// The input channel (in_valid/in_ready) carries one tick for one joint; the
// output channel (out_valid/out_ready) returns exactly one command item for it.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the ramp period
// or the motion done window, chosen by cfg_index; write it only while the block idles.
//
// Each item runs through the long division of the ramp step by 1000, the read,
// update and write back of the joint's entry in the reference memory, and then
// the impedance multiply and the final sum; a new item is taken only once the
// last one has left its final step.
//
// After reset every joint reads a zero reference and a cleared done flag: one
// valid bit per joint is cleared at once, so no clearing pass is needed.
// While the receiver stalls, the output register holds its item; the block
// still takes the next item and waits in its last step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module joint_mode_ramp_impedance_step #(
    parameter int JOINTS = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire  [0:0]         cfg_index,
    input  wire  [30:0]        cfg_data,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [3:0]         joint,
    input  wire  [2:0]         control_mode,
    input  wire                compliant,
    input  wire  signed [31:0] target_position,
    input  wire  signed [31:0] ramp_speed,
    input  wire  signed [31:0] velocity_ref,
    input  wire  signed [31:0] torque_ref,
    input  wire  signed [31:0] measured_position,
    input  wire  signed [31:0] measured_velocity,
    input  wire  [25:0]        stiffness,
    input  wire  [22:0]        damping,
    input  wire  signed [31:0] torque_offset,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [3:0]         out_joint,
    output logic [1:0]         command_kind,
    output logic signed [31:0] command_value,
    output logic               motion_done
);

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAMP,
        S_DIV,
        S_UPD,
        S_MUL,
        S_SUM
    } state_t;

    state_t state_reg, state_next;

    logic [9:0]  step_period_reg;
    logic [30:0] done_tol_reg;
    logic [JOINTS-1:0] entry_valid_reg;

    // Each entry holds {done flag, reference position}.
    logic [32:0] ref_mem [JOINTS];
    logic [32:0] rd_entry_reg;
    logic        rd_valid_reg;

    logic [3:0]         joint_reg;
    logic               joint_ok_reg;
    logic [2:0]         mode_reg;
    logic               comp_reg;
    logic signed [31:0] target_reg;
    logic signed [31:0] speed_reg;
    logic signed [31:0] vref_reg;
    logic signed [31:0] tref_reg;
    logic signed [31:0] qpos_reg;
    logic signed [31:0] qvel_reg;
    logic [25:0]        kp_reg;
    logic [22:0]        kd_reg;
    logic signed [31:0] toff_reg;

    logic signed [31:0] ref_old_reg;
    logic               done_old_reg;
    logic               move_up_reg;
    logic               move_down_reg;
    logic               speed_neg_reg;

    logic [jmris_pkg::DIV_WIDTH-1:0] div_num_reg;
    logic [jmris_pkg::DIV_WIDTH-1:0] div_quo_reg;
    logic [9:0]                      div_rem_reg;
    logic [jmris_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic signed [31:0] ref_new_reg;
    logic               done_new_reg;
    logic signed [59:0] stiff_prod_reg;
    logic signed [55:0] damp_prod_reg;

    logic               accept;
    logic               in_ok;
    logic [AW-1:0]      in_addr;
    logic [AW-1:0]      wr_addr;
    logic               is_pos_mode;
    logic               mem_we;
    logic               out_load;

    logic signed [31:0] ref_cur;
    logic               done_cur;
    logic signed [32:0] diff;
    logic signed [32:0] tol_s;
    logic [31:0]        speed_mag;
    logic [41:0]        prod_mag;

    logic [9:0]                       rem_w;
    logic [10:0]                      trial;
    logic [jmris_pkg::DIV_BITS-1:0]   qbits;

    logic signed [32:0] step;
    logic signed [33:0] sum_up;
    logic signed [33:0] sum_dn;
    logic signed [31:0] ref_upd;
    logic               done_upd;

    logic signed [32:0] pos_err;
    logic signed [61:0] acc;
    logic signed [31:0] imp_torque;
    logic [1:0]         kind_w;
    logic signed [31:0] value_w;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_ok    = ({28'd0, joint} < 32'(JOINTS));
    assign in_addr  = AW'(joint);
    assign wr_addr  = AW'(joint_reg);

    assign is_pos_mode = (mode_reg == jmris_pkg::MODE_POSITION) ||
                         (mode_reg == jmris_pkg::MODE_DIRECT);
    assign mem_we   = (state_reg == S_UPD) && joint_ok_reg && is_pos_mode;
    assign out_load = (state_reg == S_SUM) && (!out_valid || out_ready);

    // Ramp decision on the entry just read.
    always_comb
    begin
        ref_cur   = rd_valid_reg ? signed'(rd_entry_reg[31:0]) : 32'sd0;
        done_cur  = rd_valid_reg && rd_entry_reg[32];
        diff      = 33'(ref_cur) - 33'(target_reg);
        tol_s     = signed'({2'b00, done_tol_reg});
        speed_mag = speed_reg[31] ? (~unsigned'(speed_reg) + 32'd1) : unsigned'(speed_reg);
        prod_mag  = 42'(speed_mag) * 42'(step_period_reg);
    end

    // Eight restoring steps of the division by 1000 per cycle.
    always_comb
    begin
        rem_w = div_rem_reg;
        trial = 11'd0;
        qbits = '0;
        for (int i = 0; i < jmris_pkg::DIV_BITS; i++)
        begin
            trial = {rem_w, div_num_reg[jmris_pkg::DIV_WIDTH-1-i]};
            if (trial >= jmris_pkg::DIVISOR)
            begin
                rem_w = 10'(trial - jmris_pkg::DIVISOR);
                qbits[jmris_pkg::DIV_BITS-1-i] = 1'b1;
            end
            else
            begin
                rem_w = trial[9:0];
            end
        end
    end

    // New reference and done flag; truncation toward zero comes from the sign
    // being applied after the magnitude is divided.
    always_comb
    begin
        step   = speed_neg_reg ? -33'(div_quo_reg[31:0]) : 33'(div_quo_reg[31:0]);
        sum_up = 34'(ref_old_reg) + 34'(step);
        sum_dn = 34'(ref_old_reg) - 34'(step);
        ref_upd  = ref_old_reg;
        done_upd = done_old_reg;
        if (mode_reg == jmris_pkg::MODE_POSITION)
        begin
            if (move_up_reg)
            begin
                ref_upd  = jmris_pkg::sat34(sum_up);
                done_upd = 1'b0;
            end
            else if (move_down_reg)
            begin
                ref_upd  = jmris_pkg::sat34(sum_dn);
                done_upd = 1'b0;
            end
            else
            begin
                ref_upd  = target_reg;
                done_upd = 1'b1;
            end
        end
        else if (mode_reg == jmris_pkg::MODE_DIRECT)
        begin
            ref_upd = target_reg;
        end
    end

    // Impedance sum and command selection.
    always_comb
    begin
        pos_err    = 33'(qpos_reg) - 33'(ref_new_reg);
        acc        = (62'(toff_reg) <<< 16) - 62'(stiff_prod_reg) - 62'(damp_prod_reg);
        imp_torque = jmris_pkg::sat46(acc[61:16]);
        kind_w     = jmris_pkg::KIND_NONE;
        value_w    = 32'sd0;
        if (joint_ok_reg)
        begin
            if (is_pos_mode)
            begin
                kind_w  = comp_reg ? jmris_pkg::KIND_TORQUE : jmris_pkg::KIND_POSITION;
                value_w = comp_reg ? imp_torque : ref_new_reg;
            end
            else if ((mode_reg == jmris_pkg::MODE_VELOCITY) && !comp_reg)
            begin
                kind_w  = jmris_pkg::KIND_VELOCITY;
                value_w = vref_reg;
            end
            else if ((mode_reg == jmris_pkg::MODE_TORQUE) ||
                     (mode_reg == jmris_pkg::MODE_OPEN_LOOP))
            begin
                kind_w  = jmris_pkg::KIND_TORQUE;
                value_w = tref_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_RAMP;
            S_RAMP: state_next = S_DIV;
            S_DIV:
                if (div_cnt_reg == jmris_pkg::DIV_CNT_W'(jmris_pkg::DIV_CYCLES - 1))
                begin
                    state_next = S_UPD;
                end
            S_UPD:  state_next = S_MUL;
            S_MUL:  state_next = S_SUM;
            S_SUM:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_period_reg <= jmris_pkg::STEP_PERIOD_RESET;
            done_tol_reg    <= jmris_pkg::DONE_TOL_RESET;
            entry_valid_reg <= '0;
            div_cnt_reg     <= '0;
            out_valid       <= 1'b0;
            out_joint       <= '0;
            command_kind    <= jmris_pkg::KIND_NONE;
            command_value   <= '0;
            motion_done     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    jmris_pkg::CFG_STEP_PERIOD: step_period_reg <= cfg_data[9:0];
                    jmris_pkg::CFG_DONE_TOL:    done_tol_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (mem_we)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (state_reg == S_RAMP)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid     <= 1'b1;
                out_joint     <= joint_reg;
                command_kind  <= kind_w;
                command_value <= value_w;
                motion_done   <= joint_ok_reg && done_new_reg;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // Reference memory: one read at acceptance, one write back in the update step.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ref_mem[wr_addr] <= {done_upd, ref_upd};
        end
        if (accept && in_ok)
        begin
            rd_entry_reg <= ref_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            joint_reg    <= joint;
            joint_ok_reg <= in_ok;
            rd_valid_reg <= in_ok && entry_valid_reg[in_addr];
            mode_reg     <= control_mode;
            comp_reg     <= compliant;
            target_reg   <= target_position;
            speed_reg    <= ramp_speed;
            vref_reg     <= velocity_ref;
            tref_reg     <= torque_ref;
            qpos_reg     <= measured_position;
            qvel_reg     <= measured_velocity;
            kp_reg       <= stiffness;
            kd_reg       <= damping;
            toff_reg     <= torque_offset;
        end
        if (state_reg == S_RAMP)
        begin
            ref_old_reg   <= ref_cur;
            done_old_reg  <= done_cur;
            move_up_reg   <= (diff < -tol_s);
            move_down_reg <= (diff > tol_s);
            speed_neg_reg <= speed_reg[31];
            div_num_reg   <= jmris_pkg::DIV_WIDTH'(prod_mag);
            div_quo_reg   <= '0;
            div_rem_reg   <= '0;
        end
        if (state_reg == S_DIV)
        begin
            div_num_reg <= div_num_reg << jmris_pkg::DIV_BITS;
            div_quo_reg <= {div_quo_reg[jmris_pkg::DIV_WIDTH-jmris_pkg::DIV_BITS-1:0], qbits};
            div_rem_reg <= rem_w;
        end
        if (state_reg == S_UPD)
        begin
            ref_new_reg  <= ref_upd;
            done_new_reg <= done_upd;
        end
        if (state_reg == S_MUL)
        begin
            stiff_prod_reg <= signed'({1'b0, kp_reg}) * pos_err;
            damp_prod_reg  <= signed'({1'b0, kd_reg}) * qvel_reg;
        end
    end

    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second item taken while one is in flight");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (command_kind == jmris_pkg::KIND_NONE)) |-> (command_value == 32'sd0))
        else $error("no-command result carries a value");

    a_bad_joint_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ({28'd0, out_joint} >= 32'(JOINTS)))
        |-> ((command_kind == jmris_pkg::KIND_NONE) && !motion_done))
        else $error("out-of-range joint produced a command");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) &&
         (div_cnt_reg == jmris_pkg::DIV_CNT_W'(jmris_pkg::DIV_CYCLES - 1)))
        |=> (state_reg == S_UPD))
        else $error("divider did not finish on its last step");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import jmris_pkg::*;

    localparam int NUM_JOINTS = 16;

    // Modes with no command of their own.
    localparam logic [2:0] MODE_IDLE  = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_CYCLES     = 250;

    typedef struct {
        logic [3:0]         joint;
        logic [2:0]         mode;
        logic               comp;
        logic signed [31:0] target;
        logic signed [31:0] speed;
        logic signed [31:0] vref;
        logic signed [31:0] tref;
        logic signed [31:0] qpos;
        logic signed [31:0] qvel;
        logic [25:0]        kp;
        logic [22:0]        kd;
        logic signed [31:0] toff;
    } tick_t;

    typedef struct {
        logic [3:0]         joint;
        logic [1:0]         kind;
        logic signed [31:0] value;
        logic               done;
    } cmd_t;

    typedef struct {
        tick_t t;
        bit    typed;
        cmd_t  want;
    } row_t;

    logic               clk               = 1'b0;
    logic               rst_n             = 1'b0;
    logic               cfg_we            = 1'b0;
    logic [0:0]         cfg_index         = '0;
    logic [30:0]        cfg_data          = '0;
    logic               in_valid          = 1'b0;
    logic               in_ready;
    logic [3:0]         joint             = '0;
    logic [2:0]         control_mode      = '0;
    logic               compliant         = 1'b0;
    logic signed [31:0] target_position   = '0;
    logic signed [31:0] ramp_speed        = '0;
    logic signed [31:0] velocity_ref      = '0;
    logic signed [31:0] torque_ref        = '0;
    logic signed [31:0] measured_position = '0;
    logic signed [31:0] measured_velocity = '0;
    logic [25:0]        stiffness         = '0;
    logic [22:0]        damping           = '0;
    logic signed [31:0] torque_offset     = '0;
    logic               out_valid;
    logic               out_ready         = 1'b0;
    logic [3:0]         out_joint;
    logic [1:0]         command_kind;
    logic signed [31:0] command_value;
    logic               motion_done;

    // Predicted joint state and configuration.
    logic signed [31:0] ref_pos [NUM_JOINTS];
    logic               done_q  [NUM_JOINTS];
    logic [9:0]         step_period;
    logic [30:0]        done_window;

    logic signed [31:0] goal_pos [NUM_JOINTS];
    logic [3:0]         last_joint;

    cmd_t        pending_cmds [$];
    row_t        directed_rows [$];
    int unsigned err_count        = 0;
    int unsigned accepted_results = 0;
    int unsigned burst_left       = 0;

    joint_mode_ramp_impedance_step #(.JOINTS(NUM_JOINTS)) i_dut (.*);

    always #4 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("** joint_mode_ramp_impedance_step: FAILED **");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return W_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            return W_MIN;
        end
        return v[31:0];
    endfunction

    // Applies one tick to the predicted joint state and returns its command.
    function automatic cmd_t next_command(input tick_t t);
        cmd_t        c;
        longint      gap;
        longint      step;
        longint      acc;
        int unsigned j;
        j       = t.joint;
        c.joint = t.joint;
        c.kind  = KIND_NONE;
        c.value = '0;
        c.done  = 1'b0;
        if (j < NUM_JOINTS)
        begin
            if (t.mode == MODE_POSITION || t.mode == MODE_DIRECT)
            begin
                if (t.mode == MODE_POSITION)
                begin
                    gap  = longint'(ref_pos[j]) - longint'(t.target);
                    step = (longint'(t.speed) * longint'(step_period)) / 1000;
                    if (gap < -longint'(done_window))
                    begin
                        ref_pos[j] = clamp32(longint'(ref_pos[j]) + step);
                        done_q[j]  = 1'b0;
                    end
                    else if (gap > longint'(done_window))
                    begin
                        ref_pos[j] = clamp32(longint'(ref_pos[j]) - step);
                        done_q[j]  = 1'b0;
                    end
                    else
                    begin
                        ref_pos[j] = t.target;
                        done_q[j]  = 1'b1;
                    end
                end
                else
                begin
                    ref_pos[j] = t.target;
                end
                if (!t.comp)
                begin
                    c.kind  = KIND_POSITION;
                    c.value = ref_pos[j];
                end
                else
                begin
                    acc = -(longint'(t.kp) * (longint'(t.qpos) - longint'(ref_pos[j])))
                          - longint'(t.kd) * longint'(t.qvel)
                          + longint'(t.toff) * 65536;
                    c.kind  = KIND_TORQUE;
                    c.value = clamp32(acc >>> 16);
                end
            end
            else if (t.mode == MODE_VELOCITY && !t.comp)
            begin
                c.kind  = KIND_VELOCITY;
                c.value = t.vref;
            end
            else if (t.mode == MODE_TORQUE || t.mode == MODE_OPEN_LOOP)
            begin
                c.kind  = KIND_TORQUE;
                c.value = t.tref;
            end
            c.done = done_q[j];
        end
        return c;
    endfunction

    function automatic tick_t mk_tick(input logic [3:0] j, input logic [2:0] mode,
                                      input logic comp, input logic signed [31:0] target,
                                      input logic signed [31:0] speed,
                                      input logic signed [31:0] vref,
                                      input logic signed [31:0] tref,
                                      input logic signed [31:0] qpos,
                                      input logic signed [31:0] qvel,
                                      input logic [25:0] kp, input logic [22:0] kd,
                                      input logic signed [31:0] toff);
        tick_t t;
        t.joint  = j;
        t.mode   = mode;
        t.comp   = comp;
        t.target = target;
        t.speed  = speed;
        t.vref   = vref;
        t.tref   = tref;
        t.qpos   = qpos;
        t.qvel   = qvel;
        t.kp     = kp;
        t.kd     = kd;
        t.toff   = toff;
        return t;
    endfunction

    function automatic cmd_t mk_cmd(input logic [3:0] j, input logic [1:0] kind,
                                    input logic signed [31:0] value, input logic done);
        cmd_t c;
        c.joint = j;
        c.kind  = kind;
        c.value = value;
        c.done  = done;
        return c;
    endfunction

    task automatic add_row(input tick_t t, input bit typed, input cmd_t want);
        row_t r;
        r.t     = t;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return W_MIN;
            1: return W_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return int'($urandom_range(0, 262143)) - 131072;
            default: return $urandom;
        endcase
    endfunction

    // Mostly ramps on a few joints toward goals near the reference, so that
    // moves complete and the done flag toggles; the rest is noise.
    function automatic tick_t random_tick();
        tick_t       t;
        int unsigned pick;
        logic [3:0]  j;
        if ($urandom_range(0, 1) == 0)
        begin
            j = last_joint;
        end
        else
        begin
            j = $urandom_range(0, NUM_JOINTS - 1);
        end
        last_joint = j;
        t.joint    = j;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            t.mode = MODE_POSITION;
        end
        else if (pick < 62)
        begin
            t.mode = MODE_DIRECT;
        end
        else if (pick < 70)
        begin
            t.mode = MODE_VELOCITY;
        end
        else if (pick < 78)
        begin
            t.mode = MODE_TORQUE;
        end
        else if (pick < 86)
        begin
            t.mode = MODE_OPEN_LOOP;
        end
        else if (pick < 92)
        begin
            t.mode = MODE_IDLE;
        end
        else if (pick < 96)
        begin
            t.mode = MODE_RSVD6;
        end
        else
        begin
            t.mode = MODE_RSVD7;
        end
        t.comp = ($urandom_range(0, 2) == 0);
        case ($urandom_range(0, 7))
            0: goal_pos[j] = rand_word();
            1, 2: goal_pos[j] = ref_pos[j] + (int'($urandom_range(0, 8388607)) - 4194304);
            3: goal_pos[j] = ref_pos[j] + (int'($urandom_range(0, 131071)) - 65536);
            default: ;
        endcase
        t.target = goal_pos[j];
        case ($urandom_range(0, 5))
            0, 1, 2: t.speed = {1'b0, 31'($urandom)};
            3: t.speed = -int'($urandom_range(0, 100000000));
            default: t.speed = rand_word();
        endcase
        t.vref = rand_word();
        t.tref = rand_word();
        if ($urandom_range(0, 1) == 0)
        begin
            t.qpos = ref_pos[j] + (int'($urandom_range(0, 131071)) - 65536);
        end
        else
        begin
            t.qpos = rand_word();
        end
        if ($urandom_range(0, 1) == 0)
        begin
            t.qvel = int'($urandom_range(0, 131071)) - 65536;
        end
        else
        begin
            t.qvel = rand_word();
        end
        case ($urandom_range(0, 5))
            0: t.kp = '0;
            1: t.kp = '1;
            2: t.kp = 26'd65536000;
            3, 4: t.kp = $urandom_range(0, 65536000);
            default: t.kp = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0: t.kd = '0;
            1: t.kd = '1;
            2: t.kd = 23'd6553600;
            3, 4: t.kd = $urandom_range(0, 6553600);
            default: t.kd = $urandom;
        endcase
        t.toff = rand_word();
        return t;
    endfunction

    task automatic note_error(input string msg);
        if (err_count < 10)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        err_count++;
    endtask

    // Offers one item, records its command once accepted, then maybe idles.
    task automatic offer_tick(input tick_t t, input bit typed, input cmd_t want);
        cmd_t        predicted;
        int unsigned gap_cycles;
        joint             <= t.joint;
        control_mode      <= t.mode;
        compliant         <= t.comp;
        target_position   <= t.target;
        ramp_speed        <= t.speed;
        velocity_ref      <= t.vref;
        torque_ref        <= t.tref;
        measured_position <= t.qpos;
        measured_velocity <= t.qvel;
        stiffness         <= t.kp;
        damping           <= t.kd;
        torque_offset     <= t.toff;
        in_valid          <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_ready !== 1'b1);
        predicted = next_command(t);
        pending_cmds.push_back(typed ? want : predicted);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap_cycles = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap_cycles) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 20);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [30:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_STEP_PERIOD)
        begin
            step_period = value[9:0];
        end
        else
        begin
            done_window = value;
        end
        @(posedge clk);
    endtask

    // Result side: checks every accepted command and stalls on its own pattern,
    // with a long hold-off now and then so that the block backs up.
    always @(posedge clk)
    begin : result_side
        cmd_t        want;
        int unsigned hold_left    = 0;
        int unsigned next_hold_at = 300;
        logic [31:0] rx_cycle     = '0;
        if (out_valid === 1'b1 && out_ready === 1'b1)
        begin
            accepted_results++;
            if (pending_cmds.size() == 0)
            begin
                note_error($sformatf("command for joint %0d with none expected", out_joint));
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (out_joint !== want.joint || command_kind !== want.kind
                    || command_value !== want.value || motion_done !== want.done)
                begin
                    note_error($sformatf({"joint %0d/%0d kind %0d/%0d value %h/%h ",
                                          "done %0b/%0b (expected/actual)"},
                                         want.joint, out_joint, want.kind, command_kind,
                                         want.value, command_value, want.done,
                                         motion_done));
                end
            end
        end
        rx_cycle++;
        if (hold_left == 0 && accepted_results >= next_hold_at)
        begin
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + 600;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_cycle[8:6])
                3'd0, 3'd4: out_ready <= 1'b1;
                3'd1: out_ready <= ($urandom_range(0, 1) == 0);
                3'd2: out_ready <= (rx_cycle[1:0] == 2'd0);
                3'd3: out_ready <= ($urandom_range(0, 6) != 0);
                3'd5: out_ready <= rx_cycle[2];
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial
    begin : stimulus
        cmd_t        any_cmd;
        logic [9:0]  period;
        logic [30:0] window;
        any_cmd = mk_cmd(4'd0, KIND_NONE, 32'sd0, 1'b0);
        for (int i = 0; i < NUM_JOINTS; i++)
        begin
            ref_pos[i]  = '0;
            done_q[i]   = 1'b0;
            goal_pos[i] = '0;
        end
        step_period = STEP_PERIOD_RESET;
        done_window = DONE_TOL_RESET;
        last_joint  = '0;

        // A zero target from reset snaps at once and sets motion done.
        add_row(mk_tick(0, MODE_POSITION, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(0, KIND_POSITION, 0, 1));
        add_row(mk_tick(1, MODE_POSITION, 0, W_MAX, W_MAX, 0, 0, 0, 0, 0, 0, 0), 0, any_cmd);
        add_row(mk_tick(1, MODE_POSITION, 0, W_MAX, W_MAX, 0, 0, 0, 0, 0, 0, 0), 0, any_cmd);
        // Negative speed drives the reference away from its target.
        add_row(mk_tick(2, MODE_POSITION, 0, W_MIN, W_MIN, 0, 0, 0, 0, 0, 0, 0), 0, any_cmd);
        add_row(mk_tick(3, MODE_DIRECT, 0, W_MAX, 0, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(3, KIND_POSITION, W_MAX, 0));
        // Impedance torque saturating both ways, then reaching the bottom exactly.
        add_row(mk_tick(3, MODE_DIRECT, 1, W_MIN, 0, 0, 0, W_MAX, W_MAX, '1, '1, W_MAX),
                1, mk_cmd(3, KIND_TORQUE, W_MIN, 0));
        add_row(mk_tick(3, MODE_DIRECT, 1, W_MAX, 0, 0, 0, W_MIN, W_MIN, '1, '1, W_MAX),
                1, mk_cmd(3, KIND_TORQUE, W_MAX, 0));
        add_row(mk_tick(4, MODE_DIRECT, 1, 0, 0, 0, 0, 0, 0, 0, 0, W_MIN),
                1, mk_cmd(4, KIND_TORQUE, W_MIN, 0));
        add_row(mk_tick(4, MODE_POSITION, 1, 0, 0, 0, 0, 65536, -65536, 26'd65536000,
                        23'd6553600, 0), 0, any_cmd);
        add_row(mk_tick(5, MODE_VELOCITY, 0, 0, 0, W_MIN, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(5, KIND_VELOCITY, W_MIN, 0));
        add_row(mk_tick(5, MODE_VELOCITY, 0, 0, 0, W_MAX, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(5, KIND_VELOCITY, W_MAX, 0));
        // Velocity mode while compliant gives no command.
        add_row(mk_tick(6, MODE_VELOCITY, 1, 0, 0, W_MAX, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(6, KIND_NONE, 0, 0));
        add_row(mk_tick(7, MODE_TORQUE, 0, 0, 0, 0, W_MIN, 0, 0, 0, 0, 0),
                1, mk_cmd(7, KIND_TORQUE, W_MIN, 0));
        add_row(mk_tick(7, MODE_TORQUE, 1, 0, 0, 0, W_MAX, 0, 0, 0, 0, 0),
                1, mk_cmd(7, KIND_TORQUE, W_MAX, 0));
        add_row(mk_tick(8, MODE_OPEN_LOOP, 0, 0, 0, 0, -1, 0, 0, 0, 0, 0),
                1, mk_cmd(8, KIND_TORQUE, -1, 0));
        add_row(mk_tick(0, MODE_IDLE, 0, W_MAX, W_MAX, W_MAX, W_MAX, 0, 0, 0, 0, 0),
                1, mk_cmd(0, KIND_NONE, 0, 1));
        add_row(mk_tick(0, MODE_RSVD6, 0, W_MIN, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0, 0),
                1, mk_cmd(0, KIND_NONE, 0, 1));
        add_row(mk_tick(0, MODE_RSVD7, 1, W_MAX, W_MAX, W_MAX, W_MAX, 0, 0, 0, 0, 0),
                1, mk_cmd(0, KIND_NONE, 0, 1));
        // Edge of the done window: inside snaps, one past stays put with zero speed.
        add_row(mk_tick(15, MODE_POSITION, 0, 58982, 0, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(15, KIND_POSITION, 58982, 1));
        add_row(mk_tick(15, MODE_POSITION, 0, 117965, 0, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(15, KIND_POSITION, 58982, 0));
        add_row(mk_tick(15, MODE_DIRECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(15, KIND_POSITION, 0, 0));
        // The stepped reference saturates at either end.
        add_row(mk_tick(13, MODE_DIRECT, 0, 32'sh7FFF_0000, 0, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(13, KIND_POSITION, 32'sh7FFF_0000, 0));
        add_row(mk_tick(13, MODE_POSITION, 0, W_MAX, W_MAX, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(13, KIND_POSITION, W_MAX, 0));
        add_row(mk_tick(12, MODE_DIRECT, 0, 32'sh8001_0000, 0, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(12, KIND_POSITION, 32'sh8001_0000, 0));
        add_row(mk_tick(12, MODE_POSITION, 0, W_MIN, W_MAX, 0, 0, 0, 0, 0, 0, 0),
                1, mk_cmd(12, KIND_POSITION, W_MIN, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].want);
        end
        in_valid <= 1'b0;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            while (pending_cmds.size() != 0) @(posedge clk);
            @(posedge clk);
            case (phase)
                0:
                begin
                    period = 10'd1000;
                    window = '0;
                end
                1:
                begin
                    period = '0;
                    window = '1;
                end
                2:
                begin
                    period = '1;
                    window = 31'd65536;
                end
                3:
                begin
                    period = $urandom_range(1, 1000);
                    window = $urandom_range(0, 1 << 20);
                end
                4:
                begin
                    period = STEP_PERIOD_RESET;
                    window = DONE_TOL_RESET;
                end
                default:
                begin
                    period = $urandom;
                    window = $urandom;
                end
            endcase
            write_reg(CFG_STEP_PERIOD, {21'd0, period});
            write_reg(CFG_DONE_TOL, window);
            cfg_we <= 1'b0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                offer_tick(random_tick(), 1'b0, any_cmd);
            end
            in_valid <= 1'b0;
        end

        while (pending_cmds.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0 && pending_cmds.size() == 0)
        begin
            $display("** joint_mode_ramp_impedance_step: PASSED **");
        end
        else
        begin
            $display("** joint_mode_ramp_impedance_step: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/jmris_pkg.sv
hw/rtl/joint_mode_ramp_impedance_step.sv
dv/tb_top.sv
